// File: rtl/core/sit_pkg.sv
// sit_pkg: shared types and constants for the symbol intern table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package sit_pkg;
  localparam int TABLE_SLOTS  = 64;
  localparam int MAX_NAME_LEN = 32;
  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int CHAR_W = $clog2(MAX_NAME_LEN);
  localparam int LEN_W  = $clog2(MAX_NAME_LEN + 1);
  localparam int ID_W   = $clog2(TABLE_SLOTS + 1);
  localparam logic [31:0] HASH_SEED = 32'd5381;

  typedef enum logic [1:0] {
    ST_FOUND = 2'd0,
    ST_ADDED = 2'd1,
    ST_MISS  = 2'd2,
    ST_LONG  = 2'd3
  } status_t;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] name_char;
    logic       name_end;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] position;
  } out_beat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_META,
    S_CMP,
    S_STORE,
    S_DONE
  } fsm_t;
endpackage

// File: rtl/core/symbol_intern_table.sv
// symbol_intern_table: top level of the symbol intern table.
// Depends on sit_pkg.
`timescale 1ns / 1ps
// A name arrives one character per beat on in_data, with name_end on its
// last character; the operation of that beat selects add or search. A
// non-final character leaves busy low, and the next beat may follow at
// once. The final character starts a lookup that keeps busy high while
// slots are probed from hash mod 64, linearly. Each probe reads the slot
// metadata (S_PROBE, S_META), then compares the stored name one character
// at a time (S_CMP) when the stored length matches; an add of a new name
// writes it one character at a time (S_STORE) and then closes the entry.
// The result is registered and shown in S_DONE. The name memory has a
// single read port, so stored characters are read one at a time. A name
// that is too long goes straight to S_DONE. Exactly one result beat,
// marked by out_valid, follows each final character and is shown for one
// cycle; the receiver cannot stall it. Tables reset to empty at once
// through per-slot valid bits.
module symbol_intern_table
  import sit_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_beat_t  in_data,
  output logic      out_valid,
  output out_beat_t out_data
);
  // Pending name buffer, written one character per beat.
  logic [7:0] nbuf [MAX_NAME_LEN];
  logic [7:0] nbuf_rd;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic ovf_r, ovf_nxt;
  logic [31:0] hash_r, hash_nxt;
  logic op_r, op_nxt;

  // Stored names, one row of MAX_NAME_LEN characters per slot.
  logic [7:0] names_mem [TABLE_SLOTS*MAX_NAME_LEN];
  logic [7:0] names_rd_r;
  logic [LEN_W-1:0] lens_mem [TABLE_SLOTS];
  logic [SLOT_W-1:0] pos_mem [TABLE_SLOTS];
  logic [LEN_W-1:0] lens_rd_r;
  logic [SLOT_W-1:0] pos_rd_r;
  logic [TABLE_SLOTS-1:0] valid_r, valid_nxt;
  logic [ID_W-1:0] next_id_r, next_id_nxt;

  fsm_t state_r, state_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [SLOT_W:0] probes_r, probes_nxt;
  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic out_valid_r, out_valid_nxt;
  out_beat_t out_r, out_nxt;

  logic accept, final_beat;
  logic [31:0] hash_in;
  logic [CHAR_W-1:0] rd_idx;
  logic name_wr;
  logic [SLOT_W+CHAR_W-1:0] name_addr;

  assign accept = start && !busy;
  assign final_beat = accept && in_data.name_end;
  assign hash_in = (hash_r << 5) + hash_r + {24'd0, in_data.name_char};
  assign busy = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_r;
  assign rd_idx = idx_r[CHAR_W-1:0];
  assign name_addr = {slot_r, rd_idx};
  assign name_wr = (state_r == S_STORE);

  // Buffer writes and registered buffer read.
  always_ff @(posedge clk) begin
    if (accept && len_r < LEN_W'(MAX_NAME_LEN)) begin
      nbuf[len_r[CHAR_W-1:0]] <= in_data.name_char;
    end
    nbuf_rd <= nbuf[idx_nxt[CHAR_W-1:0]];
  end

  // Name memory: one port, write during store, registered read otherwise.
  always_ff @(posedge clk) begin
    if (name_wr) begin
      names_mem[name_addr] <= nbuf_rd;
    end
    names_rd_r <= names_mem[{slot_nxt, idx_nxt[CHAR_W-1:0]}];
  end

  // Slot metadata memories.
  always_ff @(posedge clk) begin
    if (state_r == S_STORE && idx_r == len_r) begin
      lens_mem[slot_r] <= len_r;
      pos_mem[slot_r] <= next_id_r[SLOT_W-1:0];
    end
    lens_rd_r <= lens_mem[slot_nxt];
    pos_rd_r <= pos_mem[slot_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r <= '0;
      ovf_r <= 1'b0;
      hash_r <= HASH_SEED;
      valid_r <= '0;
      next_id_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r <= len_nxt;
      ovf_r <= ovf_nxt;
      hash_r <= hash_nxt;
      valid_r <= valid_nxt;
      next_id_r <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    slot_r <= slot_nxt;
    probes_r <= probes_nxt;
    idx_r <= idx_nxt;
    out_r <= out_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    len_nxt = len_r;
    ovf_nxt = ovf_r;
    hash_nxt = hash_r;
    op_nxt = op_r;
    valid_nxt = valid_r;
    next_id_nxt = next_id_r;
    slot_nxt = slot_r;
    probes_nxt = probes_r;
    idx_nxt = idx_r;
    out_valid_nxt = 1'b0;
    out_nxt = out_r;
    case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (accept) begin
          if (len_r < LEN_W'(MAX_NAME_LEN)) begin
            len_nxt = len_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          hash_nxt = hash_in;
          op_nxt = in_data.operation;
          if (in_data.name_end) begin
            slot_nxt = hash_in[SLOT_W-1:0];
            probes_nxt = '0;
            if (ovf_nxt) begin
              out_valid_nxt = 1'b1;
              out_nxt = '{status: ST_LONG, position: '0};
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_PROBE;
            end
          end
        end
      end
      // Metadata read for slot_r is in flight.
      S_PROBE: begin
        state_nxt = S_META;
      end
      S_META: begin
        if (!valid_r[slot_r]) begin
          if (op_r == OP_ADD && next_id_r < ID_W'(TABLE_SLOTS)) begin
            state_nxt = S_STORE;
          end else begin
            out_valid_nxt = 1'b1;
            out_nxt = '{status: ST_MISS, position: '0};
            state_nxt = S_DONE;
          end
        end else if (lens_rd_r == len_r) begin
          idx_nxt = '0;
          if (len_r == '0) begin
            out_valid_nxt = 1'b1;
            out_nxt = '{status: ST_FOUND, position: pos_rd_r};
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_CMP;
          end
        end else begin
          state_nxt = S_PROBE;
          slot_nxt = slot_r + 1'b1;
          probes_nxt = probes_r + 1'b1;
        end
        if (state_nxt == S_PROBE && probes_nxt == (SLOT_W+1)'(TABLE_SLOTS)) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{status: ST_MISS, position: '0};
          state_nxt = S_DONE;
        end
      end
      // names_rd_r and nbuf_rd hold character idx_r.
      S_CMP: begin
        if (names_rd_r != nbuf_rd) begin
          slot_nxt = slot_r + 1'b1;
          probes_nxt = probes_r + 1'b1;
          idx_nxt = '0;
          state_nxt = S_PROBE;
          if (probes_nxt == (SLOT_W+1)'(TABLE_SLOTS)) begin
            out_valid_nxt = 1'b1;
            out_nxt = '{status: ST_MISS, position: '0};
            state_nxt = S_DONE;
          end
        end else if (idx_r == len_r - 1'b1) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{status: ST_FOUND, position: pos_rd_r};
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      // nbuf_rd holds character idx_r; written at the same index.
      S_STORE: begin
        if (idx_r == len_r) begin
          valid_nxt[slot_r] = 1'b1;
          next_id_nxt = next_id_r + 1'b1;
          out_valid_nxt = 1'b1;
          out_nxt = '{status: ST_ADDED, position: next_id_r[SLOT_W-1:0]};
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DONE: begin
        len_nxt = '0;
        ovf_nxt = 1'b0;
        hash_nxt = HASH_SEED;
        idx_nxt = '0;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// File: rtl/core/sit_checker.sv
// sit_checker: port-level assertions for symbol_intern_table, and its bind.
// Depends on sit_pkg.
`timescale 1ns / 1ps
module sit_checker
  import sit_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_beat_t  in_data,
  input logic      out_valid,
  input out_beat_t out_data
);
  // A result only comes while the block is busy with a lookup.
  a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside lookup");
  // Miss and too long carry position zero.
  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_MISS || out_data.status == ST_LONG)
    |-> out_data.position == '0) else $error("nonzero position");
  // A final character makes the block busy next cycle.
  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.name_end |=> busy) else $error("no lookup");
  // Results are single-cycle pulses.
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result");
endmodule

bind symbol_intern_table sit_checker u_sit_checker (.*);
